/* hw/rtl/c2d_pkg.sv */
// shared types, constants and register codes for the 2-d correlation engine
// no dependencies; every other file refers to it by scoped names
package c2d_pkg;

    // store geometry
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_KDIM  = 7;
    localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int KER_DEPTH = MAX_KDIM * MAX_KDIM;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int KER_AW    = $clog2(KER_DEPTH);

    // field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 12;
    localparam int VAL_W  = 16;
    localparam int ACC_W  = 37;
    localparam int PROD_W = 2 * VAL_W;
    localparam int DIM_W  = 7;
    localparam int KDIM_W = 3;

    // divider runs one quotient bit per cycle
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // apb port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = 3;

    // register indexes
    localparam logic [RIDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [RIDX_W-1:0] REG_IMG_HEIGHT = 3'd1;
    localparam logic [RIDX_W-1:0] REG_IMG_WIDTH  = 3'd2;
    localparam logic [RIDX_W-1:0] REG_KER_HEIGHT = 3'd3;
    localparam logic [RIDX_W-1:0] REG_KER_WIDTH  = 3'd4;

    // input word function codes
    localparam logic [FUNC_W-1:0] FUNC_KER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_IMG = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REQ = 2'd2;

    // effective geometry derived from the registers
    typedef struct packed {
        logic              mode;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  w;
        logic [KDIM_W-1:0] kh;
        logic [KDIM_W-1:0] kw;
        logic [DIM_W-1:0]  oh;
        logic [DIM_W-1:0]  ow;
        logic [KDIM_W-1:0] cr;
        logic [KDIM_W-1:0] cc;
        logic              empty;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic wr_ker;
        logic wr_img;
        logic req_load;
        logic div_step;
        logic mac_start;
        logic tap_issue;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

/* hw/rtl/c2d_cfg.sv */
// apb register file and derived output geometry
// depends on c2d_pkg
module c2d_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [c2d_pkg::PADDR_W-1:0]  paddr,
    input  logic [c2d_pkg::PDATA_W-1:0]  pwdata,
    output logic [c2d_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output c2d_pkg::cfg_t                cfg
);

    logic                          mode_reg;
    logic [c2d_pkg::DIM_W-1:0]     img_height_reg;
    logic [c2d_pkg::DIM_W-1:0]     img_width_reg;
    logic [c2d_pkg::KDIM_W-1:0]    ker_height_reg;
    logic [c2d_pkg::KDIM_W-1:0]    ker_width_reg;
    logic [c2d_pkg::RIDX_W-1:0]    reg_idx;
    logic                          wr_en;
    logic [c2d_pkg::DIM_W-1:0]     h_sat;
    logic [c2d_pkg::DIM_W-1:0]     w_sat;
    logic signed [c2d_pkg::DIM_W:0] oh_s;
    logic signed [c2d_pkg::DIM_W:0] ow_s;

    assign pready  = 1'b1;
    assign reg_idx = paddr[c2d_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            img_height_reg <= c2d_pkg::DIM_W'(c2d_pkg::MAX_ROWS);
            img_width_reg  <= c2d_pkg::DIM_W'(c2d_pkg::MAX_COLS);
            ker_height_reg <= c2d_pkg::KDIM_W'(3);
            ker_width_reg  <= c2d_pkg::KDIM_W'(3);
        end else if (wr_en) begin
            unique case (reg_idx)
                c2d_pkg::REG_MODE:       mode_reg       <= pwdata[0];
                c2d_pkg::REG_IMG_HEIGHT: img_height_reg <= pwdata[c2d_pkg::DIM_W-1:0];
                c2d_pkg::REG_IMG_WIDTH:  img_width_reg  <= pwdata[c2d_pkg::DIM_W-1:0];
                c2d_pkg::REG_KER_HEIGHT: ker_height_reg <= pwdata[c2d_pkg::KDIM_W-1:0];
                c2d_pkg::REG_KER_WIDTH:  ker_width_reg  <= pwdata[c2d_pkg::KDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            c2d_pkg::REG_MODE:       prdata = c2d_pkg::PDATA_W'(mode_reg);
            c2d_pkg::REG_IMG_HEIGHT: prdata = c2d_pkg::PDATA_W'(img_height_reg);
            c2d_pkg::REG_IMG_WIDTH:  prdata = c2d_pkg::PDATA_W'(img_width_reg);
            c2d_pkg::REG_KER_HEIGHT: prdata = c2d_pkg::PDATA_W'(ker_height_reg);
            c2d_pkg::REG_KER_WIDTH:  prdata = c2d_pkg::PDATA_W'(ker_width_reg);
            default:                 prdata = '0;
        endcase
    end

    // image size saturates at the store size; kernel registers cannot exceed it
    assign h_sat = (img_height_reg > c2d_pkg::DIM_W'(c2d_pkg::MAX_ROWS))
                 ? c2d_pkg::DIM_W'(c2d_pkg::MAX_ROWS) : img_height_reg;
    assign w_sat = (img_width_reg > c2d_pkg::DIM_W'(c2d_pkg::MAX_COLS))
                 ? c2d_pkg::DIM_W'(c2d_pkg::MAX_COLS) : img_width_reg;

    // output grid: full image in same mode, shrunk by kernel-1 in valid mode
    always_comb begin
        if (mode_reg) begin
            oh_s = $signed({1'b0, h_sat});
            ow_s = $signed({1'b0, w_sat});
        end else begin
            oh_s = $signed({1'b0, h_sat}) - $signed({5'b0, ker_height_reg})
                 + $signed((c2d_pkg::DIM_W+1)'(1));
            ow_s = $signed({1'b0, w_sat}) - $signed({5'b0, ker_width_reg})
                 + $signed((c2d_pkg::DIM_W+1)'(1));
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.h     = h_sat;
    assign cfg.w     = w_sat;
    assign cfg.kh    = ker_height_reg;
    assign cfg.kw    = ker_width_reg;
    assign cfg.oh    = oh_s[c2d_pkg::DIM_W-1:0];
    assign cfg.ow    = ow_s[c2d_pkg::DIM_W-1:0];
    assign cfg.cr    = mode_reg ? (ker_height_reg >> 1) : '0;
    assign cfg.cc    = mode_reg ? (ker_width_reg >> 1) : '0;
    assign cfg.empty = (h_sat == '0) || (w_sat == '0) || (ker_height_reg == '0)
                    || (ker_width_reg == '0) || (oh_s <= 0) || (ow_s <= 0);

endmodule

/* hw/rtl/c2d_ctrl.sv */
// sequencer for store writes, position divide, tap walk and result hand-off
// depends on c2d_pkg; drives the datapath through cmd_t and reads status_t
module c2d_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [c2d_pkg::FUNC_W-1:0]   s_func,
    input  c2d_pkg::status_t             status,
    output c2d_pkg::cmd_t                cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_MAC   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [c2d_pkg::DIV_CW-1:0] div_cnt_reg, div_cnt_next;
    logic                       in_acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cmd.wr_ker   = (s_func == c2d_pkg::FUNC_KER);
                    cmd.wr_img   = (s_func == c2d_pkg::FUNC_IMG);
                    cmd.req_load = (s_func == c2d_pkg::FUNC_REQ);
                    if (s_func == c2d_pkg::FUNC_REQ) begin
                        state_next   = ST_DIV;
                        div_cnt_next = '0;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == c2d_pkg::DIV_CW'(c2d_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.bad) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mac_start = 1'b1;
                    state_next    = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.tap_issue = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

/* hw/rtl/c2d_datapath.sv */
// stores, position divider, tap address stage, multiply-accumulate and result register
// depends on c2d_pkg; commanded by c2d_ctrl
module c2d_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  c2d_pkg::cfg_t                     cfg,
    input  c2d_pkg::cmd_t                     cmd,
    output c2d_pkg::status_t                  status,
    input  logic [c2d_pkg::POS_W-1:0]         s_position,
    input  logic signed [c2d_pkg::VAL_W-1:0]  s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [c2d_pkg::ACC_W-1:0]  m_conv_value,
    output logic [c2d_pkg::POS_W-1:0]         m_out_position,
    output logic                              m_is_last,
    output logic                              m_bad_request
);

    localparam int RR_W = c2d_pkg::DIM_W + 2;
    localparam int MB_W = 2 * c2d_pkg::DIM_W;

    // stores
    logic signed [c2d_pkg::VAL_W-1:0] image_mem  [c2d_pkg::IMG_DEPTH];
    logic signed [c2d_pkg::VAL_W-1:0] kernel_mem [c2d_pkg::KER_DEPTH];

    // request and divider
    logic [c2d_pkg::POS_W-1:0]  pos_reg;
    logic [c2d_pkg::POS_W-1:0]  quot_reg;
    logic [c2d_pkg::DIM_W-1:0]  rem_reg;
    logic [c2d_pkg::DIM_W:0]    rem_sh;
    logic                       div_ge;
    logic                       bad;
    logic                       last_pos;

    // tap walk
    logic [c2d_pkg::KDIM_W-1:0] kr_reg;
    logic [c2d_pkg::KDIM_W-1:0] kc_reg;
    logic [c2d_pkg::KER_AW-1:0] kidx_reg;
    logic signed [RR_W-1:0]     rr;
    logic signed [RR_W-1:0]     ccol;
    logic                       in_img;
    logic [MB_W-1:0]            row_base;
    logic [MB_W-1:0]            addr_sum;

    // pipeline
    logic                              v1_reg, v2_reg, v3_reg;
    logic                              inb1_reg, inb2_reg;
    logic [c2d_pkg::IMG_AW-1:0]        img_addr1_reg;
    logic [c2d_pkg::KER_AW-1:0]        ker_addr1_reg;
    logic signed [c2d_pkg::VAL_W-1:0]  pix2_reg;
    logic signed [c2d_pkg::VAL_W-1:0]  coef2_reg;
    logic signed [c2d_pkg::PROD_W-1:0] prod3_reg;
    logic signed [c2d_pkg::ACC_W-1:0]  acc_reg;

    // result register
    logic                              out_valid_reg;
    logic signed [c2d_pkg::ACC_W-1:0]  conv_out_reg;
    logic [c2d_pkg::POS_W-1:0]         pos_out_reg;
    logic                              last_out_reg;
    logic                              bad_out_reg;

    // store writes
    always_ff @(posedge aclk) begin
        if (cmd.wr_img && (32'(s_position) < c2d_pkg::IMG_DEPTH)) begin
            image_mem[s_position[c2d_pkg::IMG_AW-1:0]] <= s_value;
        end
        if (cmd.wr_ker && (32'(s_position) < c2d_pkg::KER_DEPTH)) begin
            kernel_mem[s_position[c2d_pkg::KER_AW-1:0]] <= s_value;
        end
    end

    // restoring divide: position by output width, one bit a cycle
    assign rem_sh = {rem_reg, quot_reg[c2d_pkg::POS_W-1]};
    assign div_ge = (rem_sh >= {1'b0, cfg.ow});

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            pos_reg  <= s_position;
            quot_reg <= s_position;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[c2d_pkg::POS_W-2:0], div_ge};
            rem_reg  <= div_ge ? c2d_pkg::DIM_W'(rem_sh - {1'b0, cfg.ow})
                               : rem_sh[c2d_pkg::DIM_W-1:0];
        end
    end

    // quotient is the output row, so the range check is row against grid height
    assign bad      = cfg.empty || (quot_reg >= c2d_pkg::POS_W'(cfg.oh));
    assign last_pos = (quot_reg == c2d_pkg::POS_W'(cfg.oh - 1'b1))
                   && (rem_reg == cfg.ow - 1'b1);

    // tap counters walk the kernel in raster order
    always_ff @(posedge aclk) begin
        if (cmd.mac_start) begin
            kr_reg   <= '0;
            kc_reg   <= '0;
            kidx_reg <= '0;
        end else if (cmd.tap_issue) begin
            kidx_reg <= kidx_reg + 1'b1;
            if (kc_reg == cfg.kw - 1'b1) begin
                kc_reg <= '0;
                kr_reg <= kr_reg + 1'b1;
            end else begin
                kc_reg <= kc_reg + 1'b1;
            end
        end
    end

    // image coordinate of the tap and its bounds check
    assign rr = $signed({2'b0, quot_reg[c2d_pkg::DIM_W-1:0]})
              + $signed({6'b0, kr_reg}) - $signed({6'b0, cfg.cr});
    assign ccol = $signed({2'b0, rem_reg})
                + $signed({6'b0, kc_reg}) - $signed({6'b0, cfg.cc});
    assign in_img = (rr >= 0) && (rr < $signed({2'b0, cfg.h}))
                 && (ccol >= 0) && (ccol < $signed({2'b0, cfg.w}));
    assign row_base = rr[c2d_pkg::DIM_W-1:0] * cfg.w;
    assign addr_sum = row_base + MB_W'(ccol[c2d_pkg::DIM_W-1:0]);

    // stage 1: addresses
    always_ff @(posedge aclk) begin
        img_addr1_reg <= addr_sum[c2d_pkg::IMG_AW-1:0];
        ker_addr1_reg <= kidx_reg;
        inb1_reg      <= in_img;
    end

    // stage 2: store reads
    always_ff @(posedge aclk) begin
        pix2_reg  <= image_mem[img_addr1_reg];
        coef2_reg <= kernel_mem[ker_addr1_reg];
        inb2_reg  <= inb1_reg;
    end

    // stage 3: signed product, padding reads as zero
    always_ff @(posedge aclk) begin
        if (inb2_reg) begin
            prod3_reg <= pix2_reg * coef2_reg;
        end else begin
            prod3_reg <= '0;
        end
    end

    // stage 4: accumulate
    always_ff @(posedge aclk) begin
        if (cmd.mac_start) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg
                     + {{(c2d_pkg::ACC_W-c2d_pkg::PROD_W){prod3_reg[c2d_pkg::PROD_W-1]}},
                        prod3_reg};
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            conv_out_reg <= bad ? '0 : acc_reg;
            pos_out_reg  <= pos_reg;
            last_out_reg <= !bad && last_pos;
            bad_out_reg  <= bad;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_conv_value   = conv_out_reg;
    assign m_out_position = pos_out_reg;
    assign m_is_last      = last_out_reg;
    assign m_bad_request  = bad_out_reg;

    assign status.bad       = bad;
    assign status.last_tap  = (kr_reg == cfg.kh - 1'b1) && (kc_reg == cfg.kw - 1'b1);
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign status.out_free  = !out_valid_reg || m_ready;

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");

    // taps are only walked for a position inside the grid
    a_tap_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tap_issue |-> !bad)
        else $error("tap issued for bad request");

    // stores are not written while the accumulator pipeline runs
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_img || cmd.wr_ker) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("store write during accumulation");

    // a loaded result waits for every tap to reach the accumulator
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result loaded before pipeline drained");

    // a bad request carries a zero sum and no last flag
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && bad_out_reg) |-> (conv_out_reg == '0 && !last_out_reg))
        else $error("bad request result not cleared");

endmodule

/* hw/rtl/conv2d_valid_or_same.sv */
// top level of the fixed-point 2-d correlation engine
// depends on c2d_pkg, c2d_cfg, c2d_ctrl, c2d_datapath
//
// input channel (s_*): each word carries func, position and value. func 0 writes a
// Q2.14 kernel coefficient, func 1 writes a signed image pixel, func 2 requests one
// output at a raster position; func 3 is dropped. writes give no result word.
// result channel (m_*): one word per request with the 37-bit raw sum (14 fraction
// bits), the echoed position, a last-position flag and a bad-request flag.
// config: apb registers mode, img_height, img_width, ker_height, ker_width at byte
// addresses 0x00..0x10; the user must write them only while the block is idle, as
// the block itself does not enforce it.
// a request goes through a position divider, then walks the kernel one tap per cycle
// through a single multiply-accumulate unit; a bad request skips the tap walk.
// one request is in flight at a time; the next word is taken as soon as the
// result is parked in the output register.
// a stalled receiver holds the result in the output register; a following request
// completes its work and waits for that register to free up.
// reset (synchronous, active low) restores the default registers and empties the
// control path; store contents are undefined until written.
module conv2d_valid_or_same (
    input  logic                              aclk,
    input  logic                              aresetn,
    // apb config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c2d_pkg::PADDR_W-1:0]       paddr,
    input  logic [c2d_pkg::PDATA_W-1:0]       pwdata,
    output logic [c2d_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [c2d_pkg::FUNC_W-1:0]        s_func,
    input  logic [c2d_pkg::POS_W-1:0]         s_position,
    input  logic signed [c2d_pkg::VAL_W-1:0]  s_value,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [c2d_pkg::ACC_W-1:0]  m_conv_value,
    output logic [c2d_pkg::POS_W-1:0]         m_out_position,
    output logic                              m_is_last,
    output logic                              m_bad_request
);

    c2d_pkg::cfg_t    cfg;
    c2d_pkg::cmd_t    cmd;
    c2d_pkg::status_t status;

    // register file
    c2d_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    c2d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // stores and arithmetic
    c2d_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_conv_value   (m_conv_value),
        .m_out_position (m_out_position),
        .m_is_last      (m_is_last),
        .m_bad_request  (m_bad_request)
    );

endmodule

/* sim/conv2d_valid_or_same_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the 2-d correlation engine: directed edge cases, then random traffic
// depends on c2d_pkg and conv2d_valid_or_same; keeps its own model of the stores and registers
module conv2d_valid_or_same_tb;

    localparam logic [c2d_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic signed [c2d_pkg::ACC_W-1:0] conv_value;
        logic [c2d_pkg::POS_W-1:0]        position;
        logic                             last;
        logic                             bad;
    } conv_word_t;

    typedef struct {
        int h, w, kh, kw;
        int oh, ow, cr, cc;
        int count;
    } grid_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              psel, penable, pwrite;
    logic [c2d_pkg::PADDR_W-1:0]       paddr;
    logic [c2d_pkg::PDATA_W-1:0]       pwdata;
    logic [c2d_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;
    logic                              s_valid;
    logic                              s_ready;
    logic [c2d_pkg::FUNC_W-1:0]        s_func;
    logic [c2d_pkg::POS_W-1:0]         s_position;
    logic signed [c2d_pkg::VAL_W-1:0]  s_value;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [c2d_pkg::ACC_W-1:0]  m_conv_value;
    logic [c2d_pkg::POS_W-1:0]         m_out_position;
    logic                              m_is_last;
    logic                              m_bad_request;

    // register copies
    logic                       cfg_mode;
    logic [c2d_pkg::DIM_W-1:0]  cfg_h, cfg_w;
    logic [c2d_pkg::KDIM_W-1:0] cfg_kh, cfg_kw;

    // store copies and which entries hold data
    logic signed [c2d_pkg::VAL_W-1:0] img_mem [c2d_pkg::IMG_DEPTH];
    logic signed [c2d_pkg::VAL_W-1:0] ker_mem [c2d_pkg::KER_DEPTH];
    bit                               img_loaded [c2d_pkg::IMG_DEPTH];
    bit                               ker_loaded [c2d_pkg::KER_DEPTH];

    conv_word_t pending_sums[$];

    int tx_idle_pct = 35;
    int rx_idle_pct = 64;
    int errors = 0;
    int words_sent = 0;
    int words_dropped = 0;
    int results_checked = 0;
    int bad_seen = 0;
    int settings_used = 0;
    int cycle_count = 0;

    conv2d_valid_or_same uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_conv_value   (m_conv_value),
        .m_out_position (m_out_position),
        .m_is_last      (m_is_last),
        .m_bad_request  (m_bad_request)
    );

    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_sums.size());
            $display("conv2d_valid_or_same_tb: errors");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0d ns: mismatch: %s", $time, what);
    endtask

    // effective geometry from the register copies
    function automatic grid_t grid_now();
        grid_t g;
        g.h  = (cfg_h > c2d_pkg::MAX_ROWS) ? c2d_pkg::MAX_ROWS : int'(cfg_h);
        g.w  = (cfg_w > c2d_pkg::MAX_COLS) ? c2d_pkg::MAX_COLS : int'(cfg_w);
        g.kh = int'(cfg_kh);
        g.kw = int'(cfg_kw);
        if (cfg_mode) begin
            g.oh = g.h;
            g.ow = g.w;
            g.cr = g.kh / 2;
            g.cc = g.kw / 2;
        end else begin
            g.oh = g.h - g.kh + 1;
            g.ow = g.w - g.kw + 1;
            g.cr = 0;
            g.cc = 0;
        end
        if (g.h == 0 || g.w == 0 || g.kh == 0 || g.kw == 0 || g.oh <= 0 || g.ow <= 0)
            g.count = 0;
        else
            g.count = g.oh * g.ow;
        return g;
    endfunction

    // expected result word for one output request
    function automatic conv_word_t correlate(input logic [c2d_pkg::POS_W-1:0] pos);
        conv_word_t res;
        grid_t g;
        longint acc;
        int r, c, pr, pc;
        g = grid_now();
        acc = 0;
        res.position = pos;
        if (int'(pos) >= g.count) begin
            res.conv_value = '0;
            res.last = 1'b0;
            res.bad = 1'b1;
            return res;
        end
        r = int'(pos) / g.ow;
        c = int'(pos) % g.ow;
        for (int kr = 0; kr < g.kh; kr++) begin
            for (int kc = 0; kc < g.kw; kc++) begin
                pr = r + kr - g.cr;
                pc = c + kc - g.cc;
                if (pr >= 0 && pr < g.h && pc >= 0 && pc < g.w)
                    acc += longint'(img_mem[pr * g.w + pc])
                         * longint'(ker_mem[kr * g.kw + kc]);
            end
        end
        res.conv_value = acc[c2d_pkg::ACC_W-1:0];
        res.last = (int'(pos) == g.count - 1);
        res.bad = 1'b0;
        return res;
    endfunction

    // one input word through the handshake, then into the model
    task automatic send_word(input logic [c2d_pkg::FUNC_W-1:0] func,
                             input logic [c2d_pkg::POS_W-1:0] pos,
                             input logic [c2d_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        case (func)
            c2d_pkg::FUNC_KER: begin
                if (pos < c2d_pkg::KER_DEPTH) begin
                    ker_mem[c2d_pkg::KER_AW'(pos)] = val;
                    ker_loaded[c2d_pkg::KER_AW'(pos)] = 1'b1;
                    words_sent++;
                end else begin
                    words_dropped++;
                end
            end
            c2d_pkg::FUNC_IMG: begin
                img_mem[pos] = val;
                img_loaded[pos] = 1'b1;
                words_sent++;
            end
            c2d_pkg::FUNC_REQ: begin
                pending_sums.push_back(correlate(pos));
                words_sent++;
            end
            default: words_dropped++;
        endcase
    endtask

    // sender holds off until every result is back
    task automatic wait_results(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_sums.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // load any coefficient or pixel the window would read that holds no data yet
    task automatic load_window(input logic [c2d_pkg::POS_W-1:0] pos);
        grid_t g;
        int r, c, pr, pc, kidx, pidx;
        g = grid_now();
        if (int'(pos) >= g.count)
            return;
        r = int'(pos) / g.ow;
        c = int'(pos) % g.ow;
        for (int kr = 0; kr < g.kh; kr++) begin
            for (int kc = 0; kc < g.kw; kc++) begin
                kidx = kr * g.kw + kc;
                if (!ker_loaded[kidx])
                    send_word(c2d_pkg::FUNC_KER, c2d_pkg::POS_W'(kidx),
                              c2d_pkg::VAL_W'($urandom));
                pr = r + kr - g.cr;
                pc = c + kc - g.cc;
                pidx = pr * g.w + pc;
                if (pr >= 0 && pr < g.h && pc >= 0 && pc < g.w && !img_loaded[pidx])
                    send_word(c2d_pkg::FUNC_IMG, c2d_pkg::POS_W'(pidx),
                              c2d_pkg::VAL_W'($urandom));
            end
        end
    endtask

    task automatic request_output(input logic [c2d_pkg::POS_W-1:0] pos);
        load_window(pos);
        send_word(c2d_pkg::FUNC_REQ, pos, c2d_pkg::VAL_W'($urandom));
    endtask

    // apb write, then read back
    task automatic cfg_write(input logic [c2d_pkg::RIDX_W-1:0] idx,
                             input logic [c2d_pkg::PDATA_W-1:0] data);
        logic [c2d_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            c2d_pkg::REG_MODE:       cfg_mode = data[0];
            c2d_pkg::REG_IMG_HEIGHT: cfg_h    = data[c2d_pkg::DIM_W-1:0];
            c2d_pkg::REG_IMG_WIDTH:  cfg_w    = data[c2d_pkg::DIM_W-1:0];
            c2d_pkg::REG_KER_HEIGHT: cfg_kh   = data[c2d_pkg::KDIM_W-1:0];
            c2d_pkg::REG_KER_WIDTH:  cfg_kw   = data[c2d_pkg::KDIM_W-1:0];
            default: ;
        endcase
        if (got !== data)
            report_mismatch($sformatf("register %0d reads 0x%0h, wrote 0x%0h", idx, got, data));
    endtask

    // new geometry, only once the block has gone quiet
    task automatic set_geometry(input logic mode, input int h, input int w,
                                input int kh, input int kw);
        wait_results(SETTLE_CYCLES);
        cfg_write(c2d_pkg::REG_MODE, c2d_pkg::PDATA_W'(mode));
        cfg_write(c2d_pkg::REG_IMG_HEIGHT, c2d_pkg::PDATA_W'(h));
        cfg_write(c2d_pkg::REG_IMG_WIDTH, c2d_pkg::PDATA_W'(w));
        cfg_write(c2d_pkg::REG_KER_HEIGHT, c2d_pkg::PDATA_W'(kh));
        cfg_write(c2d_pkg::REG_KER_WIDTH, c2d_pkg::PDATA_W'(kw));
        settings_used++;
    endtask

    // reset geometry: field extremes, ignored words, first and last outputs, bad positions
    task automatic test_word_extremes();
        send_word(c2d_pkg::FUNC_KER, 0, 16'h8000);
        send_word(c2d_pkg::FUNC_KER, 8, 16'h7fff);
        send_word(c2d_pkg::FUNC_IMG, 0, 16'h7fff);
        send_word(c2d_pkg::FUNC_IMG, 4095, 16'h8000);
        send_word(FUNC_NONE, 4095, 16'hffff);
        send_word(c2d_pkg::FUNC_KER, c2d_pkg::POS_W'(c2d_pkg::KER_DEPTH), 16'h1234);
        send_word(c2d_pkg::FUNC_KER, 4095, 16'h7fff);
        request_output(0);
        request_output(3843);
        request_output(3844);
        request_output(4095);
    endtask

    // zero padding at the corners, odd and even kernels
    task automatic test_same_padding();
        set_geometry(1'b1, 64, 64, 7, 7);
        request_output(0);
        request_output(4095);
        set_geometry(1'b1, 5, 5, 4, 2);
        request_output(0);
        request_output(24);
        request_output(25);
    endtask

    // grids with no outputs, saturated sizes, single-output grids
    task automatic test_empty_and_saturated();
        set_geometry(1'b0, 2, 64, 3, 3);
        request_output(0);
        set_geometry(1'b1, 0, 5, 3, 3);
        request_output(0);
        set_geometry(1'b1, 5, 5, 0, 3);
        request_output(0);
        set_geometry(1'b1, 127, 100, 1, 1);
        request_output(4095);
        set_geometry(1'b0, 7, 7, 7, 7);
        request_output(0);
        request_output(1);
        set_geometry(1'b0, 1, 1, 1, 1);
        request_output(0);
        request_output(1);
    endtask

    function automatic int random_dim(input int small_max);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 64;
        else if (pick < 12)
            return 1;
        else if (pick < 14)
            return 0;
        else if (pick < 16)
            return $urandom_range(65, 127);
        return $urandom_range(1, small_max);
    endfunction

    // random geometries, each followed by a burst of mostly valid requests
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int budget);
        grid_t g;
        int stop_at, burst_end, pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            set_geometry(1'($urandom_range(1)), random_dim(12), random_dim(12),
                         ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7),
                         ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7));
            g = grid_now();
            burst_end = words_sent + $urandom_range(20, 60);
            while (words_sent < burst_end && words_sent < stop_at) begin
                pick = $urandom_range(99);
                if (pick < 68 && g.count > 0)
                    request_output(c2d_pkg::POS_W'($urandom_range(g.count - 1)));
                else if (pick < 74 && g.count > 0)
                    request_output(c2d_pkg::POS_W'(g.count - 1));
                else if (pick < 82)
                    request_output((g.count < 4096)
                                   ? c2d_pkg::POS_W'($urandom_range(g.count, 4095))
                                   : c2d_pkg::POS_W'($urandom_range(4095)));
                else if (pick < 88)
                    send_word(c2d_pkg::FUNC_KER, c2d_pkg::POS_W'($urandom_range(63)),
                              c2d_pkg::VAL_W'($urandom));
                else if (pick < 95)
                    send_word(c2d_pkg::FUNC_IMG, c2d_pkg::POS_W'($urandom_range(4095)),
                              c2d_pkg::VAL_W'($urandom));
                else if (pick < 98)
                    send_word(FUNC_NONE, c2d_pkg::POS_W'($urandom),
                              c2d_pkg::VAL_W'($urandom));
                else
                    wait_results(0);
            end
        end
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        conv_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result word at position %0d",
                                          m_out_position));
            end else begin
                want = pending_sums.pop_front();
                results_checked++;
                if (want.bad)
                    bad_seen++;
                if (m_out_position !== want.position)
                    report_mismatch($sformatf("position %0d, want %0d",
                                              m_out_position, want.position));
                if (m_conv_value !== want.conv_value)
                    report_mismatch($sformatf("position %0d: sum %0d, want %0d",
                                              want.position, m_conv_value, want.conv_value));
                if (m_is_last !== want.last)
                    report_mismatch($sformatf("position %0d: last flag %b, want %b",
                                              want.position, m_is_last, want.last));
                if (m_bad_request !== want.bad)
                    report_mismatch($sformatf("position %0d: bad flag %b, want %b",
                                              want.position, m_bad_request, want.bad));
            end
        end
    end

    // test sequence
    initial begin
        aresetn    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        s_valid    <= 1'b0;
        s_func     <= FUNC_NONE;
        s_position <= '0;
        s_value    <= '0;
        cfg_mode = 1'b0;
        cfg_h    = 7'd64;
        cfg_w    = 7'd64;
        cfg_kh   = 3'd3;
        cfg_kw   = 3'd3;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_word_extremes();
        test_same_padding();
        test_empty_and_saturated();
        test_random_traffic(35, 64, 250);
        test_random_traffic(64, 35, 250);
        test_random_traffic(0, 0, 250);
        wait_results(SETTLE_CYCLES);

        if (pending_sums.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
        $display("%0d words accepted (%0d dropped), %0d results checked, %0d bad requests",
                 words_sent, words_dropped, results_checked, bad_seen);
        $display("%0d register settings, valid and same sizes, under three idle mixes",
                 settings_used);
        if (errors == 0)
            $display("conv2d_valid_or_same_tb: clean");
        else
            $display("conv2d_valid_or_same_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/c2d_pkg.sv
hw/rtl/c2d_cfg.sv
hw/rtl/c2d_ctrl.sv
hw/rtl/c2d_datapath.sv
hw/rtl/conv2d_valid_or_same.sv
sim/conv2d_valid_or_same_tb.sv
